// File: design/eac3_sync_frame_splitter_defines.svh
// ----------------------------------------------------------------------------
// eac3 sync frame splitter assertion macros
// shared property wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef EAC3_SYNC_FRAME_SPLITTER_DEFINES_SVH
`define EAC3_SYNC_FRAME_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define EAC3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define EAC3_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define EAC3_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EAC3_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: design/eac3_sfs_pkg.sv
// ----------------------------------------------------------------------------
// eac3 sync frame splitter package
// result kinds, error codes and sync word constants
// ----------------------------------------------------------------------------
package eac3_sfs_pkg;

	localparam int HEADER_BYTES_DEF = 7;
	// power of two
	localparam int FIFO_DEPTH = 4;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SMALL     = 3'd1;
	localparam logic [2:0] ERR_SYNC_WORD = 3'd2;
	localparam logic [2:0] ERR_SYNC_LEN  = 3'd3;
	localparam logic [2:0] ERR_REMAINDER = 3'd4;

	localparam logic [7:0] SYNC_HI = 8'h0b;
	localparam logic [7:0] SYNC_LO = 8'h77;
	localparam logic [10:0] SLEN_MASK = 11'h7ff;

endpackage

// File: design/eac3_sfs_in_if.sv
// ----------------------------------------------------------------------------
// eac3 sync frame splitter input channel
// frame start and data byte items with valid/ready
// ----------------------------------------------------------------------------
interface eac3_sfs_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] frame_len;
	logic [7:0]  data_byte;

	modport source (output valid, func, frame_len, data_byte, input ready);
	modport sink (input valid, func, frame_len, data_byte, output ready);
endinterface

// File: design/eac3_sfs_out_if.sv
// ----------------------------------------------------------------------------
// eac3 sync frame splitter result channel
// passed frame starts, data bytes and errors with valid/ready
// ----------------------------------------------------------------------------
interface eac3_sfs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic        sub_start;
	logic [12:0] sub_len;
	logic [15:0] frame_len_out;
	logic [2:0]  err_code;
	logic        last;

	modport source (output valid, out_kind, out_byte, sub_start, sub_len, frame_len_out,
		err_code, last, input ready);
	modport sink (input valid, out_kind, out_byte, sub_start, sub_len, frame_len_out,
		err_code, last, output ready);
endinterface

// File: design/eac3_sync_frame_splitter.sv
// a result passes through the input register, the result queue and the output register
// throughput: one input item per cycle while data bytes pass through and the result queue has room
// a released header is sent one byte per output transfer; the 4-entry result queue
// absorbs part of it, so input can stall during each sync frame
// reset: arst_n clears control state; no frame active, header buffer holds no data
// ----------------------------------------------------------------------------
// eac3 sync frame splitter
// checks each sync frame header of a framed byte stream, releases it with a
// sub-frame start mark or reports an error, and passes the body bytes through
// ----------------------------------------------------------------------------
`include "eac3_sync_frame_splitter_defines.svh"

module eac3_sync_frame_splitter
	import eac3_sfs_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	eac3_sfs_in_if.sink frames,
	eac3_sfs_out_if.source results
);

	localparam int NEED_W = $clog2(HEADER_BYTES + 1);
	localparam int IDX_W  = $clog2(HEADER_BYTES);
	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam logic [NEED_W-1:0] NEED_FULL = NEED_W'(HEADER_BYTES);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HEADER_BYTES - 1);

	typedef struct packed {
		logic                         grp;
		logic [1:0]                   kind;
		logic [2:0]                   err;
		logic [15:0]                  flen;
		logic [12:0]                  slen;
		logic [HEADER_BYTES-1:0][7:0] bytes;
	} rec_t;

	// input register
	logic        valid_s1;
	logic        func_s1;
	logic [15:0] flen_s1;
	logic [7:0]  byte_s1;

	// splitter state
	logic              active_q;
	logic [NEED_W-1:0] need_q;
	logic [15:0]       frame_q;
	logic [11:0]       body_q;
	logic [7:0]        hbuf_q [HEADER_BYTES-1];

	// result queue
	rec_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fifo_cnt_q;
	logic [IDX_W-1:0] hdr_idx_q;

	// output register
	logic        res_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic        sub_start_q;
	logic [12:0] sub_len_q;
	logic [15:0] flen_q;
	logic [2:0]  err_q;
	logic        last_q;

	logic adv;
	logic push;
	logic pop;
	logic out_load;

	rec_t              rec;
	logic              rec_vld;
	logic              active_d;
	logic [NEED_W-1:0] need_d;
	logic [15:0]       frame_d;
	logic [11:0]       body_d;
	logic [NEED_W-1:0] need_eff;
	logic              hb_wr;
	logic [IDX_W-1:0]  hb_idx;
	logic [7:0]        hdr [HEADER_BYTES];
	logic [11:0]       slen_half;
	logic [12:0]       slen;
	logic [15:0]       rem;
	rec_t              head;

	assign adv = valid_s1 && (fifo_cnt_q < CNT_W'(FIFO_DEPTH));
	assign frames.ready = !valid_s1 || adv;
	assign push = adv && rec_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			func_s1 <= frames.func;
			flen_s1 <= frames.frame_len;
			byte_s1 <= frames.data_byte;
		end
	end

	always_comb begin
		for (int i = 0; i < HEADER_BYTES - 1; i++) begin
			hdr[i] = hbuf_q[i];
		end
		hdr[HEADER_BYTES-1] = byte_s1;
	end

	assign need_eff  = (need_q == '0 && body_q == '0) ? NEED_FULL : need_q;
	assign hb_idx    = IDX_W'(NEED_FULL - need_eff);
	assign slen_half = 12'(({hdr[2], hdr[3]} & {5'd0, SLEN_MASK})) + 12'd1;
	assign slen      = {slen_half, 1'b0};
	assign rem       = frame_q - 16'(slen);

	always_comb begin
		rec      = '0;
		rec_vld  = 1'b0;
		active_d = active_q;
		need_d   = need_q;
		frame_d  = frame_q;
		body_d   = body_q;
		hb_wr    = 1'b0;
		if (!func_s1) begin
			rec_vld = 1'b1;
			if (flen_s1 < 16'(HEADER_BYTES)) begin
				rec.kind = KIND_ERR;
				rec.err  = ERR_SMALL;
				active_d = 1'b0;
			end else begin
				rec.kind = KIND_START;
				rec.flen = flen_s1;
				active_d = 1'b1;
				frame_d  = flen_s1;
				need_d   = NEED_FULL;
				body_d   = '0;
			end
		end else if (active_q) begin
			if (need_eff == '0) begin
				rec_vld       = 1'b1;
				rec.kind      = KIND_DATA;
				rec.bytes[0]  = byte_s1;
				body_d        = body_q - 12'd1;
				if (body_q == 12'd1) begin
					need_d = NEED_FULL;
				end
			end else if (need_eff != NEED_W'(1)) begin
				hb_wr  = 1'b1;
				need_d = need_eff - NEED_W'(1);
			end else begin
				rec_vld  = 1'b1;
				need_d   = '0;
				if (hdr[0] != SYNC_HI || hdr[1] != SYNC_LO) begin
					rec.kind = KIND_ERR;
					rec.err  = ERR_SYNC_WORD;
					active_d = 1'b0;
				end else if (slen < 13'(HEADER_BYTES) || 16'(slen) > frame_q) begin
					rec.kind = KIND_ERR;
					rec.err  = ERR_SYNC_LEN;
					active_d = 1'b0;
				end else if (rem != '0 && rem < 16'(HEADER_BYTES)) begin
					rec.kind = KIND_ERR;
					rec.err  = ERR_REMAINDER;
					active_d = 1'b0;
				end else begin
					rec.grp  = 1'b1;
					rec.kind = KIND_DATA;
					rec.slen = slen;
					for (int i = 0; i < HEADER_BYTES; i++) begin
						rec.bytes[i] = hdr[i];
					end
					frame_d = rem;
					body_d  = 12'(slen - 13'(HEADER_BYTES));
					if (slen == 13'(HEADER_BYTES)) begin
						need_d = NEED_FULL;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			need_q   <= NEED_FULL;
			frame_q  <= '0;
			body_q   <= '0;
		end else if (adv) begin
			active_q <= active_d;
			need_q   <= need_d;
			frame_q  <= frame_d;
			body_q   <= body_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hb_wr) begin
			hbuf_q[hb_idx] <= byte_s1;
		end
	end

	// result queue and header expansion
	assign head     = fifo_q[rd_q];
	assign out_load = (fifo_cnt_q != '0) && (!res_valid_q || results.ready);
	assign pop      = out_load && (!head.grp || hdr_idx_q == IDX_LAST);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			fifo_cnt_q <= '0;
			hdr_idx_q  <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(push) - CNT_W'(pop);
			if (pop) begin
				hdr_idx_q <= '0;
			end else if (out_load) begin
				hdr_idx_q <= hdr_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || results.ready) begin
			res_valid_q <= fifo_cnt_q != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q      <= head.kind;
			byte_q      <= head.bytes[head.grp ? hdr_idx_q : '0];
			sub_start_q <= head.grp && hdr_idx_q == '0;
			sub_len_q   <= (head.grp && hdr_idx_q == '0) ? head.slen : '0;
			flen_q      <= head.flen;
			err_q       <= head.err;
			last_q      <= !head.grp || hdr_idx_q == IDX_LAST;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.out_kind      = kind_q;
	assign results.out_byte      = byte_q;
	assign results.sub_start     = sub_start_q;
	assign results.sub_len       = sub_len_q;
	assign results.frame_len_out = flen_q;
	assign results.err_code      = err_q;
	assign results.last          = last_q;

	`EAC3_ASSERT_NEVER(a_fifo_over, clk, arst_n, fifo_cnt_q > CNT_W'(FIFO_DEPTH))
	`EAC3_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && fifo_cnt_q == '0)
	`EAC3_ASSERT_IMPL(a_idx_grp, clk, arst_n, hdr_idx_q != '0, fifo_cnt_q != '0 && head.grp)
	`EAC3_ASSERT_IMPL(a_sub_data, clk, arst_n, results.valid && results.sub_start, results.out_kind == KIND_DATA && !results.last)
	`EAC3_ASSERT_IMPL(a_err_stop, clk, arst_n, push && rec.kind == KIND_ERR, !active_d)

endmodule

// File: dv/eac3_sync_frame_splitter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac3 sync frame splitter checker
// watches both channels, predicts the results of every input transfer and
// compares each result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
package eac3_sfs_tb_pkg;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_BYTE  = 1'b1;

endpackage

module eac3_sync_frame_splitter_checker
	import eac3_sfs_pkg::*;
	import eac3_sfs_tb_pkg::*;
#(
	parameter int HDR = HEADER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	eac3_sfs_in_if frames,
	eac3_sfs_out_if results,
	output int errors,
	output int pending
);

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        sub_start;
		logic [12:0] sub_len;
		logic [15:0] frame_len;
		logic [2:0]  err;
		logic        last;
	} split_res_t;

	split_res_t split_q[$];
	logic [7:0] hdr_bytes[HDR];
	int hdr_need = HDR;
	int frame_left = 0;
	int body_left = 0;
	bit in_frame = 1'b0;

	function automatic void push_res(logic [1:0] kind, logic [7:0] data, logic ss,
		logic [12:0] slen, logic [15:0] flen, logic [2:0] err, logic last);
		split_res_t r;
		r.kind = kind;
		r.data = data;
		r.sub_start = ss;
		r.sub_len = slen;
		r.frame_len = flen;
		r.err = err;
		r.last = last;
		split_q.push_back(r);
	endfunction

	function automatic void flag_error(logic [2:0] code);
		in_frame = 1'b0;
		push_res(KIND_ERR, 8'd0, 1'b0, 13'd0, 16'd0, code, 1'b1);
	endfunction

	function automatic void split_item(logic f, logic [15:0] fl, logic [7:0] b);
		int slen;
		int i;
		if (f == FUNC_START) begin
			if (fl < HDR) begin
				flag_error(ERR_SMALL);
				return;
			end
			in_frame = 1'b1;
			frame_left = fl;
			hdr_need = HDR;
			body_left = 0;
			push_res(KIND_START, 8'd0, 1'b0, 13'd0, fl, ERR_NONE, 1'b1);
			return;
		end
		if (!in_frame)
			return;
		if (hdr_need == 0 && body_left == 0)
			hdr_need = HDR;
		if (hdr_need == 0) begin
			body_left--;
			if (body_left == 0)
				hdr_need = HDR;
			push_res(KIND_DATA, b, 1'b0, 13'd0, 16'd0, ERR_NONE, 1'b1);
			return;
		end
		hdr_bytes[HDR - hdr_need] = b;
		hdr_need--;
		if (hdr_need > 0)
			return;
		if (hdr_bytes[0] != SYNC_HI || hdr_bytes[1] != SYNC_LO) begin
			flag_error(ERR_SYNC_WORD);
			return;
		end
		slen = (int'({hdr_bytes[2], hdr_bytes[3]} & 16'(SLEN_MASK)) + 1) * 2;
		if (slen < HDR || slen > frame_left) begin
			flag_error(ERR_SYNC_LEN);
			return;
		end
		frame_left -= slen;
		if (frame_left > 0 && frame_left < HDR) begin
			flag_error(ERR_REMAINDER);
			return;
		end
		for (i = 0; i < HDR; i++)
			push_res(KIND_DATA, hdr_bytes[i], i == 0, (i == 0) ? 13'(slen) : 13'd0,
				16'd0, ERR_NONE, i == HDR - 1);
		body_left = slen - HDR;
		if (body_left == 0)
			hdr_need = HDR;
	endfunction

	function automatic void check_field(string name, int exp, int act);
		if (exp != act) begin
			$error("%s expected %0d actual %0d", name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		split_res_t want;
		if (arst_n) begin
			if (frames.valid && frames.ready)
				split_item(frames.func, frames.frame_len, frames.data_byte);
			if (results.valid && results.ready) begin
				if (split_q.size() == 0) begin
					$error("unexpected result transfer, out_kind %0d", results.out_kind);
					errors++;
				end else begin
					want = split_q.pop_front();
					check_field("out_kind", want.kind, results.out_kind);
					check_field("out_byte", want.data, results.out_byte);
					check_field("sub_start", want.sub_start, results.sub_start);
					check_field("sub_len", want.sub_len, results.sub_len);
					check_field("frame_len_out", want.frame_len, results.frame_len_out);
					check_field("err_code", want.err, results.err_code);
					check_field("last", want.last, results.last);
				end
			end
		end
		pending = split_q.size();
	end

endmodule

// File: dv/eac3_sync_frame_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac3 sync frame splitter testbench
// directed edge cases then random frames of sync frames, well-formed and
// broken, with random idling on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module eac3_sync_frame_splitter_tb;
	import eac3_sfs_pkg::*;
	import eac3_sfs_tb_pkg::*;

	localparam int FRAME_ITEMS = 270;
	localparam int HOLD_CYCLES = 150;
	localparam int HDR = HEADER_BYTES_DEF;

	logic clk = 1'b0;
	logic arst_n;
	int errors;
	int pending;
	bit calm = 1'b0;
	bit rx_hold = 1'b0;
	int sent = 0;

	eac3_sfs_in_if frames_if();
	eac3_sfs_out_if results_if();

	eac3_sync_frame_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames_if),
		.results(results_if)
	);

	eac3_sync_frame_splitter_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames_if),
		.results(results_if),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic put_item(logic f, logic [15:0] fl, logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 6) begin
			frames_if.valid <= 1'b0;
			@(posedge clk);
		end
		frames_if.valid <= 1'b1;
		frames_if.func <= f;
		frames_if.frame_len <= fl;
		frames_if.data_byte <= b;
		@(posedge clk);
		while (!frames_if.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_start(logic [15:0] fl);
		put_item(FUNC_START, fl, 8'($urandom));
	endtask

	task automatic send_byte(logic [7:0] b);
		put_item(FUNC_BYTE, 16'($urandom), b);
	endtask

	// sync word, 11-bit length code, rest of header and body
	function automatic void add_sync(ref logic [7:0] q[$], input logic [10:0] n);
		q.push_back(SYNC_HI);
		q.push_back(SYNC_LO);
		q.push_back({5'($urandom), n[10:8]});
		q.push_back(n[7:0]);
		repeat ((int'(n) + 1) * 2 - 4)
			q.push_back(8'($urandom));
	endfunction

	task automatic play(ref logic [7:0] q[$], input int count);
		int i;
		for (i = 0; i < count; i++)
			send_byte(q[i]);
	endtask

	task automatic random_frame(bit clean);
		logic [7:0] q[$];
		logic [10:0] n;
		int start_at[3];
		int nsub;
		int pick;
		int total;
		int fl;
		int cut;
		int i;
		nsub = $urandom_range(1, 3);
		for (i = 0; i < nsub; i++) begin
			n = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(6, 40))
				: 11'($urandom_range(3, 5));
			start_at[i] = q.size();
			add_sync(q, n);
		end
		total = q.size();
		fl = total;
		cut = total;
		pick = clean ? 0 : $urandom_range(0, 99);
		if (pick >= 70 && pick < 75) begin
			// frame too small, body bytes then dropped
			fl = $urandom_range(0, HDR - 1);
			cut = $urandom_range(0, 3);
		end else if (pick >= 75 && pick < 80) begin
			fl = total + $urandom_range(1, HDR - 1);
		end else if (pick >= 80 && pick < 85) begin
			fl = total - $urandom_range(1, 6);
		end else if (pick >= 85 && pick < 90) begin
			i = $urandom_range(0, nsub - 1);
			q[start_at[i] + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
		end else if (pick >= 90 && pick < 95) begin
			// cut short, next frame start restarts
			cut = $urandom_range(1, total - 1);
		end else if (pick >= 95) begin
			// bytes past the end of the frame form a new header
			if ($urandom_range(0, 1)) begin
				q.push_back(SYNC_HI);
				q.push_back(SYNC_LO);
			end
			while (q.size() < total + HDR)
				q.push_back(8'($urandom));
			cut = q.size();
		end
		send_start(16'(fl));
		play(q, cut);
		if (pick >= 70)
			repeat ($urandom_range(0, 2))
				send_byte(8'($urandom));
	endtask

	initial begin
		results_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				rx_hold = 1'b0;
			end
			results_if.ready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	initial begin
		logic [7:0] q[$];
		int idx;
		arst_n <= 1'b0;
		frames_if.valid <= 1'b0;
		frames_if.func <= FUNC_BYTE;
		frames_if.frame_len <= 16'd0;
		frames_if.data_byte <= 8'd0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		// bytes with no frame, then frame starts too small for a header
		send_byte(8'h00);
		send_byte(8'hff);
		send_start(16'd0);
		send_start(16'(HDR - 1));
		// longest sync frame, cut short by a restart
		add_sync(q, 11'h7ff);
		send_start(16'hffff);
		play(q, HDR + 3);
		// sync frame shorter than a header
		q = {};
		add_sync(q, 11'd2);
		send_start(16'(HDR));
		play(q, HDR);
		send_byte(8'($urandom));
		// remainder too small for another header
		q = {};
		add_sync(q, 11'd3);
		send_start(16'd10);
		play(q, HDR);

		@(posedge clk);
		wait (pending == 0);

		for (idx = 0; sent < FRAME_ITEMS; idx++) begin
			calm = (idx >= 6 && idx < 10);
			if (idx == 3)
				rx_hold = 1'b1;
			if (idx == 11) begin
				@(posedge clk);
				wait (pending == 0);
			end
			random_frame(idx == 3 || idx == 4);
		end
		frames_if.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (20)
			@(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS eac3_sync_frame_splitter");
		else
			$display("FAIL eac3_sync_frame_splitter");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAIL eac3_sync_frame_splitter");
		$finish;
	end

endmodule
